// ----- src/kscl_pkg.sv -----
`timescale 1ns / 1ps

package kscl_pkg;

    localparam int CODE_LENGTH_DEFAULT = 4;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // register indexes
    localparam logic [1:0] REG_CODE_DIGITS = 2'd0;
    localparam logic [1:0] REG_DWELL_TICKS = 2'd1;
    localparam logic [1:0] REG_FLASH_TICKS = 2'd2;
    localparam logic [1:0] REG_ERROR_TICKS = 2'd3;

    localparam logic [15:0] CODE_DIGITS_RESET = 16'd22898;
    localparam logic [7:0]  DWELL_TICKS_RESET = 8'd35;
    localparam logic [11:0] FLASH_TICKS_RESET = 12'd500;
    localparam logic [12:0] ERROR_TICKS_RESET = 13'd2000;

    localparam logic [6:0] LED_SUCCESS = 7'd7;
    localparam logic [6:0] LED_ERROR   = 7'd112;
    localparam logic [6:0] LED_OFF     = 7'd0;

    localparam logic [1:0] VERDICT_ENTERING = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
    localparam logic [1:0] VERDICT_REJECTED = 2'd2;

    localparam logic [3:0] KEY_STAR  = 4'd10;
    localparam logic [3:0] KEY_HASH  = 4'd11;
    localparam logic [1:0] LAST_ROW  = 2'd3;
    localparam logic [1:0] LAST_COL  = 2'd2;
    localparam logic [1:0] LAST_FLASH_STEP = 2'd3;

    typedef enum logic [4:0] {
        PH_SCAN  = 5'b00001,
        PH_HOLD  = 5'b00010,
        PH_DWELL = 5'b00100,
        PH_FLASH = 5'b01000,
        PH_ERROR = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [15:0] code_digits;
        logic [7:0]  dwell_ticks;
        logic [11:0] flash_ticks;
        logic [12:0] error_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] digits_entered;
        logic [6:0] led_pattern;
        logic       buzzer;
        logic [3:0] row_drive;
    } result_t;

    // digit of the key at a row and column
    function automatic logic [3:0] key_digit(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] d;
        d = 4'd0;
        if (row == LAST_ROW) begin
            unique case (col)
                2'd0:    d = KEY_STAR;
                2'd1:    d = 4'd0;
                2'd2:    d = KEY_HASH;
                default: d = 4'd0;
            endcase
        end else begin
            d = 4'({2'b00, row} * 4'd3 + {2'b00, col} + 4'd1);
        end
        return d;
    endfunction

    function automatic logic [12:0] at_least_one(input logic [12:0] v);
        return (v == 13'd0) ? 13'd1 : v;
    endfunction

endpackage

// ----- src/kscl_regs.sv -----
`timescale 1ns / 1ps

module kscl_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kscl_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [kscl_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [kscl_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output kscl_pkg::cfg_t                      cfg
);

    kscl_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_index;
    logic           wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.code_digits <= kscl_pkg::CODE_DIGITS_RESET;
            cfg_reg.dwell_ticks <= kscl_pkg::DWELL_TICKS_RESET;
            cfg_reg.flash_ticks <= kscl_pkg::FLASH_TICKS_RESET;
            cfg_reg.error_ticks <= kscl_pkg::ERROR_TICKS_RESET;
        end else if (wr_en) begin
            unique case (reg_index)
                kscl_pkg::REG_CODE_DIGITS: cfg_reg.code_digits <= pwdata[15:0];
                kscl_pkg::REG_DWELL_TICKS: cfg_reg.dwell_ticks <= pwdata[7:0];
                kscl_pkg::REG_FLASH_TICKS: cfg_reg.flash_ticks <= pwdata[11:0];
                kscl_pkg::REG_ERROR_TICKS: cfg_reg.error_ticks <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            kscl_pkg::REG_CODE_DIGITS: prdata = {16'd0, cfg_reg.code_digits};
            kscl_pkg::REG_DWELL_TICKS: prdata = {24'd0, cfg_reg.dwell_ticks};
            kscl_pkg::REG_FLASH_TICKS: prdata = {20'd0, cfg_reg.flash_ticks};
            kscl_pkg::REG_ERROR_TICKS: prdata = {19'd0, cfg_reg.error_ticks};
            default:                   prdata = '0;
        endcase
    end

endmodule

// ----- src/kscl_core.sv -----
`timescale 1ns / 1ps

module kscl_core #(
    parameter int CODE_LENGTH = kscl_pkg::CODE_LENGTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [2:0]          column_levels,
    input  kscl_pkg::cfg_t      cfg,
    output kscl_pkg::result_t   result
);

    localparam int CW = $clog2(CODE_LENGTH + 1);
    localparam int IW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    kscl_pkg::phase_t phase_reg, phase_next;
    logic [1:0]   row_reg, row_next;
    logic [1:0]   col_reg, col_next;
    logic [12:0]  timer_reg, timer_next;
    logic [CW-1:0] count_reg, count_next;
    logic         buzzer_reg, buzzer_next;
    logic [1:0]   flash_reg, flash_next;
    logic [3:0]   digits_reg [CODE_LENGTH];
    logic         digit_wr;
    logic [3:0]   digit_val;

    logic [3:0]   cols_ext;
    logic         high;
    logic         match;
    logic [31:0]  code_ext;
    logic         room;

    assign cols_ext = {1'b0, column_levels};
    assign high     = (col_reg != 2'd3) && cols_ext[col_reg];
    assign code_ext = {16'd0, cfg.code_digits};
    assign room     = (count_reg < CW'(CODE_LENGTH));

    always_comb begin
        match = 1'b1;
        for (int k = 0; k < CODE_LENGTH; k++) begin
            if (digits_reg[k] != code_ext[4*k +: 4]) match = 1'b0;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        timer_next  = timer_reg;
        count_next  = count_reg;
        buzzer_next = buzzer_reg;
        flash_next  = flash_reg;
        digit_wr    = 1'b0;
        digit_val   = kscl_pkg::key_digit(row_reg, col_reg);

        unique case (phase_reg)
            kscl_pkg::PH_SCAN: begin
                if (col_reg != 2'd3 && high && room) begin
                    digit_wr    = 1'b1;
                    count_next  = count_reg + CW'(1);
                    buzzer_next = ~buzzer_reg;
                    phase_next  = kscl_pkg::PH_HOLD;
                end else if (col_reg >= kscl_pkg::LAST_COL) begin
                    // column three is treated as the last column
                    col_next   = kscl_pkg::LAST_COL;
                    phase_next = kscl_pkg::PH_DWELL;
                    timer_next = kscl_pkg::at_least_one({5'd0, cfg.dwell_ticks});
                end else begin
                    col_next = col_reg + 2'd1;
                end
            end
            kscl_pkg::PH_HOLD: begin
                if (high) begin
                    buzzer_next = ~buzzer_reg;
                end else if (col_reg >= kscl_pkg::LAST_COL) begin
                    phase_next = kscl_pkg::PH_DWELL;
                    timer_next = kscl_pkg::at_least_one({5'd0, cfg.dwell_ticks});
                end else begin
                    col_next   = col_reg + 2'd1;
                    phase_next = kscl_pkg::PH_SCAN;
                end
            end
            kscl_pkg::PH_DWELL: begin
                if (timer_reg <= 13'd1) begin
                    if (row_reg == kscl_pkg::LAST_ROW && !room) begin
                        buzzer_next = 1'b0;
                        if (match) begin
                            phase_next = kscl_pkg::PH_FLASH;
                            flash_next = 2'd0;
                            timer_next = kscl_pkg::at_least_one({1'b0, cfg.flash_ticks});
                        end else begin
                            phase_next = kscl_pkg::PH_ERROR;
                            timer_next = kscl_pkg::at_least_one(cfg.error_ticks);
                        end
                    end else begin
                        row_next   = row_reg + 2'd1;
                        col_next   = 2'd0;
                        phase_next = kscl_pkg::PH_SCAN;
                    end
                end else begin
                    timer_next = timer_reg - 13'd1;
                end
            end
            kscl_pkg::PH_FLASH: begin
                if (timer_reg <= 13'd1) begin
                    if (flash_reg >= kscl_pkg::LAST_FLASH_STEP) begin
                        phase_next = kscl_pkg::PH_SCAN;
                        row_next   = 2'd0;
                        col_next   = 2'd0;
                        timer_next = 13'd0;
                        count_next = '0;
                        flash_next = 2'd0;
                    end else begin
                        flash_next = flash_reg + 2'd1;
                        timer_next = kscl_pkg::at_least_one({1'b0, cfg.flash_ticks});
                    end
                end else begin
                    timer_next = timer_reg - 13'd1;
                end
            end
            kscl_pkg::PH_ERROR: begin
                if (timer_reg <= 13'd1) begin
                    phase_next = kscl_pkg::PH_SCAN;
                    row_next   = 2'd0;
                    col_next   = 2'd0;
                    timer_next = 13'd0;
                    count_next = '0;
                    flash_next = 2'd0;
                end else begin
                    timer_next = timer_reg - 13'd1;
                end
            end
            default: begin
                phase_next = kscl_pkg::PH_SCAN;
            end
        endcase
    end

    always_comb begin
        result.buzzer         = buzzer_next;
        result.digits_entered = 3'(count_next);
        result.row_drive      = 4'd0;
        result.led_pattern    = kscl_pkg::LED_OFF;
        result.verdict        = kscl_pkg::VERDICT_ENTERING;
        if (phase_next == kscl_pkg::PH_FLASH) begin
            result.verdict     = kscl_pkg::VERDICT_ACCEPTED;
            result.led_pattern = flash_next[0] ? kscl_pkg::LED_OFF : kscl_pkg::LED_SUCCESS;
        end else if (phase_next == kscl_pkg::PH_ERROR) begin
            result.verdict     = kscl_pkg::VERDICT_REJECTED;
            result.led_pattern = kscl_pkg::LED_ERROR;
        end else begin
            result.row_drive = 4'd1 << row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= kscl_pkg::PH_SCAN;
            row_reg    <= 2'd0;
            col_reg    <= 2'd0;
            timer_reg  <= 13'd0;
            count_reg  <= '0;
            buzzer_reg <= 1'b0;
            flash_reg  <= 2'd0;
        end else if (step) begin
            phase_reg  <= phase_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            timer_reg  <= timer_next;
            count_reg  <= count_next;
            buzzer_reg <= buzzer_next;
            flash_reg  <= flash_next;
        end
    end

    // digit store, written at the fill position
    always_ff @(posedge aclk) begin
        if (step && digit_wr) begin
            digits_reg[count_reg[IW-1:0]] <= digit_val;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CODE_LENGTH))
        else $error("digit count beyond code length");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (count_reg == $past(count_reg) ||
                  count_reg == $past(count_reg) + CW'(1) || count_reg == '0))
        else $error("digit count jumped");

    a_quiet_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == kscl_pkg::PH_FLASH || phase_reg == kscl_pkg::PH_ERROR) |-> !buzzer_reg)
        else $error("buzzer active while verdict shows");

    a_verdict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == kscl_pkg::PH_DWELL && phase_next != kscl_pkg::PH_DWELL &&
         phase_next != kscl_pkg::PH_SCAN) |-> !room)
        else $error("verdict reached with digits missing");
`endif

endmodule

// ----- src/keypad_scan_code_lock.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake            tdata fields (lowest bit up)
// s_        in         s_tvalid / s_tready  column_levels[2:0]
// m_        out        m_tvalid / m_tready  row_drive, buzzer, led_pattern,
//                                           digits_entered, verdict
// apb       in         psel/penable/pready  code_digits, dwell_ticks,
//                                           flash_ticks, error_ticks
//
// one item per cycle sustained while m_tready stays high; each item is held in
// the input register and leaves through the result register
// an accepted item reaches m_tvalid via the input and then the result register
// the keypad state advances only when an item moves into the result register
// a stalled result does not block the input register from holding one more item
// synchronous active-low reset puts the lock at row 0 with no digits

module keypad_scan_code_lock #(
    parameter int CODE_LENGTH = kscl_pkg::CODE_LENGTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tick items: column_levels [2:0], zero fill [7:3]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kscl_pkg::IN_TDATA_W-1:0]     s_tdata,
    // result items: row_drive [3:0], buzzer [4], led_pattern [11:5],
    // digits_entered [14:12], verdict [16:15], zero fill [23:17]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kscl_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kscl_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [kscl_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [kscl_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    kscl_pkg::cfg_t    cfg;
    kscl_pkg::result_t result;

    // input register
    logic       in_valid_reg;
    logic [2:0] cols_reg;
    // result register
    logic              out_valid_reg;
    kscl_pkg::result_t out_data_reg;

    logic advance;

    // item moves forward when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(kscl_pkg::OUT_TDATA_W - $bits(kscl_pkg::result_t)){1'b0}},
                       out_data_reg};

    kscl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kscl_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .column_levels (cols_reg),
        .cfg           (cfg),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cols_reg <= s_tdata[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

// ----- tb/tb_keypad_scan_code_lock.sv -----
`timescale 1ns / 1ps

// self-checking bench for the keypad scanner and code lock
// every tick item gives exactly one result item, checked in order against a local model
module tb_keypad_scan_code_lock;
    import kscl_pkg::*;

    localparam int CODE_LEN    = CODE_LENGTH_DEFAULT;
    localparam int CYCLE_LIMIT = 2_000_000;

    // a few ticks to start with: all columns low, all high, single columns and pairs
    localparam logic [2:0] DIRECTED_TICKS [25] = '{
        3'd0, 3'd7, 3'd7, 3'd0, 3'd1, 3'd2, 3'd4, 3'd6, 3'd5, 3'd3, 3'd7, 3'd0, 3'd2,
        3'd2, 3'd0, 3'd4, 3'd4, 3'd4, 3'd0, 3'd7, 3'd1, 3'd0, 3'd3, 3'd0, 3'd7
    };

    // local copy of the lock state
    typedef struct packed {
        phase_t           ph;
        logic [1:0]       row;
        logic [1:0]       col;
        logic [12:0]      timer;
        logic [3:0][3:0]  digits;
        logic [2:0]       count;
        logic             buzz;
        logic [1:0]       fstep;
    } lock_state_t;

    localparam lock_state_t LOCK_RESET = '{
        ph: PH_SCAN, row: 2'd0, col: 2'd0, timer: 13'd0, digits: '0,
        count: 3'd0, buzz: 1'b0, fstep: 2'd0
    };

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr    = '0;
    logic [CFG_DATA_W-1:0]   pwdata   = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    cfg_t        lock_cfg;           // register values as the block should hold them
    lock_state_t lock_state;         // state that predicts accepted ticks
    lock_state_t plan_state;         // state seen by the stimulus planner, runs ahead
    logic [2:0]  tick_queue[$];      // column levels waiting to be sent
    result_t     expected_results[$];
    logic [3:0]  aim[4];             // digits the planner tries to key in this sweep
    bit          noisy_sweep = 1'b0;
    int          error_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycle_count   = 0;

    keypad_scan_code_lock dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    // a zero timing register behaves as one tick
    function automatic logic [12:0] timer_load(input logic [12:0] v);
        return (v == 13'd0) ? 13'd1 : v;
    endfunction

    function automatic lock_state_t restart_attempt(input lock_state_t s);
        s.ph    = PH_SCAN;
        s.row   = 2'd0;
        s.col   = 2'd0;
        s.timer = 13'd0;
        s.count = 3'd0;
        s.fstep = 2'd0;
        return s;
    endfunction

    // after the last column the row dwells, otherwise the next column is tested
    function automatic lock_state_t advance_column(input lock_state_t s);
        if (s.col >= LAST_COL) begin
            s.ph    = PH_DWELL;
            s.timer = timer_load(13'(lock_cfg.dwell_ticks));
        end else begin
            s.col = s.col + 2'd1;
            s.ph  = PH_SCAN;
        end
        return s;
    endfunction

    // one tick of the lock: next state and the result item it produces
    function automatic void lock_step(input lock_state_t cur, input logic [2:0] cols,
                                      output lock_state_t nxt, output result_t res);
        lock_state_t s;
        logic        hit;
        logic        match;
        logic [3:0]  d;
        s   = cur;
        hit = (s.col == 2'd3) ? 1'b0 : cols[s.col];
        case (s.ph)
            PH_SCAN: begin
                if (s.col == 2'd3) begin
                    s.col = LAST_COL;
                    s = advance_column(s);
                end else if (hit && s.count < CODE_LEN) begin
                    // bottom row holds star, zero and hash
                    if (s.row == LAST_ROW) begin
                        d = (s.col == 2'd0) ? KEY_STAR : (s.col == 2'd1) ? 4'd0 : KEY_HASH;
                    end else begin
                        d = 4'(s.row * 3 + s.col + 1);
                    end
                    s.digits[s.count[1:0]] = d;
                    s.count = s.count + 3'd1;
                    s.buzz  = ~s.buzz;
                    s.ph    = PH_HOLD;
                end else begin
                    s = advance_column(s);
                end
            end
            PH_HOLD: begin
                if (hit) s.buzz = ~s.buzz;
                else s = advance_column(s);
            end
            PH_DWELL: begin
                if (s.timer <= 13'd1) begin
                    if (s.row == LAST_ROW && s.count >= CODE_LEN) begin
                        match = 1'b1;
                        for (int k = 0; k < 4; k++) begin
                            if (s.digits[k] != lock_cfg.code_digits[4*k +: 4]) match = 1'b0;
                        end
                        s.buzz = 1'b0;
                        if (match) begin
                            s.ph    = PH_FLASH;
                            s.fstep = 2'd0;
                            s.timer = timer_load(13'(lock_cfg.flash_ticks));
                        end else begin
                            s.ph    = PH_ERROR;
                            s.timer = timer_load(lock_cfg.error_ticks);
                        end
                    end else begin
                        // next row, or row 0 after a short sweep; digits are kept
                        s.row = s.row + 2'd1;
                        s.col = 2'd0;
                        s.ph  = PH_SCAN;
                    end
                end else begin
                    s.timer = s.timer - 13'd1;
                end
            end
            PH_FLASH: begin
                if (s.timer <= 13'd1) begin
                    if (s.fstep >= LAST_FLASH_STEP) begin
                        s = restart_attempt(s);
                    end else begin
                        s.fstep = s.fstep + 2'd1;
                        s.timer = timer_load(13'(lock_cfg.flash_ticks));
                    end
                end else begin
                    s.timer = s.timer - 13'd1;
                end
            end
            default: begin
                if (s.timer <= 13'd1) s = restart_attempt(s);
                else s.timer = s.timer - 13'd1;
            end
        endcase

        res.buzzer         = s.buzz;
        res.digits_entered = s.count;
        if (s.ph == PH_FLASH) begin
            res.verdict     = VERDICT_ACCEPTED;
            res.led_pattern = s.fstep[0] ? LED_OFF : LED_SUCCESS;
            res.row_drive   = 4'd0;
        end else if (s.ph == PH_ERROR) begin
            res.verdict     = VERDICT_REJECTED;
            res.led_pattern = LED_ERROR;
            res.row_drive   = 4'd0;
        end else begin
            res.verdict     = VERDICT_ENTERING;
            res.led_pattern = LED_OFF;
            res.row_drive   = 4'(1) << s.row;
        end
        nxt = s;
    endfunction

    // queue one tick and advance the planner
    function automatic void push_tick(input logic [2:0] cols);
        lock_state_t nxt;
        result_t     unused;
        lock_step(plan_state, cols, nxt, unused);
        plan_state = nxt;
        tick_queue.push_back(cols);
    endfunction

    // a code made of keypad digits, now and then with one that cannot be keyed
    function automatic logic [15:0] keypad_code();
        logic [15:0] c;
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 9) == 0) c[4*k +: 4] = 4'($urandom_range(12, 15));
            else c[4*k +: 4] = 4'($urandom_range(0, 11));
        end
        return c;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // wait at a falling edge until nothing is queued, in flight or expected
    task automatic wait_idle();
        do @(negedge aclk);
        while (tick_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CODE_DIGITS: lock_cfg.code_digits = val[15:0];
            REG_DWELL_TICKS: lock_cfg.dwell_ticks = val[7:0];
            REG_FLASH_TICKS: lock_cfg.flash_ticks = val[11:0];
            default:         lock_cfg.error_ticks = val[12:0];
        endcase
    endtask

    // plan budget ticks in all; mostly proper key presses while scanning
    task automatic queue_ticks(input int budget, input int bias, input int noise);
        int         active;
        logic [2:0] cols;
        logic [3:0] want;
        logic [1:0] krow;
        logic [1:0] kcol;
        active = 0;
        while (active < budget) begin
            // fresh aim at the top of every sweep that has no digits yet
            if (plan_state.ph == PH_SCAN && plan_state.row == 2'd0 && plan_state.col == 2'd0
                    && plan_state.count == 3'd0) begin
                noisy_sweep = ($urandom_range(0, 99) < noise);
                for (int k = 0; k < 4; k++) begin
                    want = lock_cfg.code_digits[4*k +: 4];
                    if ($urandom_range(0, 99) >= bias || want > KEY_HASH) begin
                        want = 4'($urandom_range(0, 11));
                    end
                    aim[k] = want;
                end
            end
            cols = 3'($urandom_range(0, 7));
            if (!noisy_sweep && plan_state.col != 2'd3) begin
                if (plan_state.ph == PH_SCAN && plan_state.count < CODE_LEN) begin
                    want = aim[plan_state.count[1:0]];
                    if (want == 4'd0) begin
                        krow = LAST_ROW;
                        kcol = 2'd1;
                    end else if (want == KEY_STAR) begin
                        krow = LAST_ROW;
                        kcol = 2'd0;
                    end else if (want == KEY_HASH) begin
                        krow = LAST_ROW;
                        kcol = LAST_COL;
                    end else begin
                        krow = 2'((want - 4'd1) / 4'd3);
                        kcol = 2'((want - 4'd1) % 4'd3);
                    end
                    // the wanted key is nearly always pressed, a stray one rarely
                    if (krow == plan_state.row && kcol == plan_state.col) begin
                        cols[plan_state.col] = ($urandom_range(0, 9) != 0);
                    end else begin
                        cols[plan_state.col] = ($urandom_range(0, 19) == 0);
                    end
                end else if (plan_state.ph == PH_HOLD) begin
                    cols[plan_state.col] = ($urandom_range(0, 2) != 0);
                end
            end
            push_tick(cols);
            active++;
        end
    endtask

    // write all registers, then send two batches with a full drain between them
    task automatic run_phase(input logic [15:0] code, input logic [7:0] dwell,
                             input logic [11:0] flash, input logic [12:0] err,
                             input int s_idle, input int r_idle, input int budget,
                             input int bias, input int noise);
        apb_write(REG_CODE_DIGITS, 32'(code));
        apb_write(REG_DWELL_TICKS, 32'(dwell));
        apb_write(REG_FLASH_TICKS, 32'(flash));
        apb_write(REG_ERROR_TICKS, 32'(err));
        @(negedge aclk);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        queue_ticks(budget / 2, bias, noise);
        wait_idle();
        queue_ticks(budget - budget / 2, bias, noise);
        wait_idle();
    endtask

    // sender: one tick item per handshake, each accepted item is predicted at once
    always @(posedge aclk) begin : tick_driver
        lock_state_t nxt;
        result_t     res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                lock_step(lock_state, s_tdata[2:0], nxt, res);
                lock_state = nxt;
                expected_results.push_back(res);
            end
            if (!s_tvalid || s_tready) begin
                if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tdata  <= IN_TDATA_W'(tick_queue.pop_front());
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure, every result item checked field by field
    always @(posedge aclk) begin : result_monitor
        result_t want;
        result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(result_t)-1:0];
                if (expected_results.size() == 0) begin
                    $error("result item with none expected");
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("row_drive", want.row_drive, got.row_drive);
                    check_field("buzzer", want.buzzer, got.buzzer);
                    check_field("led_pattern", want.led_pattern, got.led_pattern);
                    check_field("digits_entered", want.digits_entered, got.digits_entered);
                    check_field("verdict", want.verdict, got.verdict);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_keypad_scan_code_lock: errors");
            $finish;
        end
    end

    initial begin
        lock_cfg.code_digits = CODE_DIGITS_RESET;
        lock_cfg.dwell_ticks = DWELL_TICKS_RESET;
        lock_cfg.flash_ticks = FLASH_TICKS_RESET;
        lock_cfg.error_ticks = ERROR_TICKS_RESET;
        lock_state = LOCK_RESET;
        plan_state = LOCK_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values first, sender idling a quarter of the time, receiver half
        @(negedge aclk);
        send_idle_pct = 25;
        recv_idle_pct = 51;
        foreach (DIRECTED_TICKS[i]) push_tick(DIRECTED_TICKS[i]);
        queue_ticks(60, 50, 20);
        wait_idle();

        // fastest timing, then the slowest timing with a code that can never match
        run_phase(keypad_code(), 8'd1, 12'd1, 13'd1, 25, 51, 450, 50, 20);
        run_phase(16'hFFFF, 8'hFF, 12'hFFF, 13'h1FFF, 25, 51, 40, 0, 10);

        // idling swapped: zero timing registers with an all-zero code, then a longer flash
        run_phase(16'h0000, 8'd0, 12'd0, 13'd0, 51, 25, 300, 60, 20);
        run_phase(keypad_code(), 8'd2, 12'd40, 13'd1, 51, 25, 80, 100, 0);
        run_phase(keypad_code(), 8'($urandom_range(1, 6)), 12'($urandom_range(1, 12)),
                  13'($urandom_range(1, 20)), 51, 25, 300, 50, 20);

        // no idling on either side
        run_phase(keypad_code(), 8'($urandom_range(1, 6)), 12'($urandom_range(1, 12)),
                  13'($urandom_range(1, 20)), 0, 0, 300, 50, 20);
        run_phase(keypad_code(), 8'($urandom_range(1, 4)), 12'($urandom_range(1, 6)),
                  13'($urandom_range(1, 10)), 0, 0, 200, 70, 30);

        wait_idle();
        // a stray late result would show up within the pipeline depth
        repeat (8) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_keypad_scan_code_lock: clean");
        end else begin
            $display("tb_keypad_scan_code_lock: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/kscl_pkg.sv
src/kscl_regs.sv
src/kscl_core.sv
src/keypad_scan_code_lock.sv
tb/tb_keypad_scan_code_lock.sv
